>>> hw/rtl/dns_name_label_encoder_macros.svh
// Assertion macros for the DNS name label encoder top level.
`ifndef DNS_NAME_LABEL_ENCODER_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define DNLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define DNLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/dnle_pkg.sv
// Package of types, constants and helpers for the DNS name label encoder.
`default_nettype none

package dnle_pkg;

	localparam int unsigned POS_W       = 14;
	localparam int unsigned LEN_W       = 7;
	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned CNT_W       = 2;

	localparam logic [POS_W-1:0]  PACKET_LIMIT = POS_W'(9000);
	localparam logic [LEN_W-1:0]  MAX_LABEL    = LEN_W'(63);
	localparam logic [POS_W-1:0]  POS_MAX      = '1;
	localparam logic [CHAR_W-1:0] DOT_CHAR     = 8'h2E;

	typedef enum logic [1:0] {
		ST_BUSY = 2'd0,
		ST_OK   = 2'd1,
		ST_LONG = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_byte;
		logic [POS_W-1:0]  out_pos;
		logic              write_valid;
		status_t           status;
		logic              name_done;
	} result_t;

	typedef struct packed {
		logic             load;
		logic [CNT_W-1:0] count;
	} rbuf_ctl_t;

	function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
		return (p == POS_MAX) ? POS_MAX : p + POS_W'(1);
	endfunction

	function automatic result_t mk_result(input logic [CHAR_W-1:0] b,
			input logic [POS_W-1:0] p, input logic v, input status_t s,
			input logic d);
		result_t r;
		r.out_byte    = b;
		r.out_pos     = p;
		r.write_valid = v;
		r.status      = s;
		r.name_done   = d;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dnle_encode.sv
// Name encoding state and the single-pass logic that turns one character into its writes.
`default_nettype none

module dnle_encode (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      take,
	input  wire logic [dnle_pkg::CHAR_W-1:0] name_char,
	input  wire logic                      first_char,
	input  wire logic                      last_char,
	input  wire logic                      empty_name,
	input  wire logic [dnle_pkg::POS_W-1:0] start_offset,
	output dnle_pkg::rbuf_ctl_t            ctl,
	output dnle_pkg::result_t              res [dnle_pkg::MAX_RESULTS]
);
	import dnle_pkg::*;

	logic [POS_W-1:0] next_pos_q, label_start_q;
	logic [LEN_W-1:0] label_len_q;
	logic             name_failed_q;

	logic [POS_W-1:0] np, ls;
	logic [LEN_W-1:0] ll;
	logic             nf;
	logic [CNT_W-1:0] n;
	status_t          fail;
	logic             is_dot;

	always_comb begin
		np     = next_pos_q;
		ls     = label_start_q;
		ll     = label_len_q;
		nf     = name_failed_q;
		n      = '0;
		fail   = ST_BUSY;
		is_dot = (name_char == DOT_CHAR);
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i] = '0;
		end
		if (empty_name) begin
			if (first_char) begin
				ls = start_offset;
				ll = '0;
				nf = 1'b1;
				n  = CNT_W'(1);
				if (start_offset >= PACKET_LIMIT) begin
					res[0] = mk_result('0, '0, 1'b0, ST_FULL, 1'b1);
					np     = start_offset;
				end else begin
					res[0] = mk_result('0, start_offset, 1'b1, ST_OK, 1'b1);
					np     = pos_inc(start_offset);
				end
			end
		end else begin
			if (first_char) begin
				nf = 1'b0;
				ll = '0;
				ls = start_offset;
				np = pos_inc(start_offset);
			end
			if (!nf) begin
				if (!is_dot) begin
					if (ll >= MAX_LABEL) begin
						fail = ST_LONG;
					end else if (np >= PACKET_LIMIT) begin
						fail = ST_FULL;
					end else begin
						res[n] = mk_result(name_char, np, 1'b1, ST_BUSY, 1'b0);
						n      = n + CNT_W'(1);
						np     = pos_inc(np);
						ll     = ll + LEN_W'(1);
					end
				end else begin
					if (ls >= PACKET_LIMIT) begin
						fail = ST_FULL;
					end else begin
						res[n] = mk_result({1'b0, ll}, ls, 1'b1, ST_BUSY, 1'b0);
						n      = n + CNT_W'(1);
						if (!last_char) begin
							ls = np;
							np = pos_inc(np);
							ll = '0;
						end
					end
				end
				// Closing the name: patch the open label unless the character is a dot, then the zero terminator.
				if (fail == ST_BUSY && last_char) begin
					if (!is_dot) begin
						if (ls >= PACKET_LIMIT) begin
							fail = ST_FULL;
						end else begin
							res[n] = mk_result({1'b0, ll}, ls, 1'b1, ST_BUSY, 1'b0);
							n      = n + CNT_W'(1);
						end
					end
					if (fail == ST_BUSY) begin
						if (np >= PACKET_LIMIT) begin
							fail = ST_FULL;
						end else begin
							res[n] = mk_result('0, np, 1'b1, ST_OK, 1'b1);
							n      = n + CNT_W'(1);
							np     = pos_inc(np);
							nf     = 1'b1;
						end
					end
				end
				if (fail != ST_BUSY) begin
					res[n] = mk_result('0, '0, 1'b0, fail, 1'b1);
					n      = n + CNT_W'(1);
					nf     = 1'b1;
				end
			end
		end
	end

	assign ctl.load  = take;
	assign ctl.count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_pos_q    <= '0;
			label_start_q <= '0;
			label_len_q   <= '0;
			name_failed_q <= 1'b0;
		end else if (take) begin
			next_pos_q    <= np;
			label_start_q <= ls;
			label_len_q   <= ll;
			name_failed_q <= nf;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/dnle_rbuf.sv
// Result buffer: holds up to three writes of one character and hands them out in order.
`default_nettype none

module dnle_rbuf (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dnle_pkg::rbuf_ctl_t   ctl,
	input  wire dnle_pkg::result_t     res [dnle_pkg::MAX_RESULTS],
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output dnle_pkg::result_t          out_res,
	output logic                       room
);
	import dnle_pkg::*;

	result_t          ent_q [MAX_RESULTS];
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign out_res   = ent_q[0];
	assign pop       = out_valid && out_ready;
	// Room for a fresh set when empty or once the last held entry leaves in this cycle.
	assign room      = (cnt_q == '0) || (cnt_q == CNT_W'(1) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= ctl.count;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				ent_q[i] <= res[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/dns_name_label_encoder.sv
// Top level of the DNS name label encoder: input register, encoder and result buffer.
//
// Usage: a dotted name enters on the slave stream one character per transfer;
// tlast marks its final character, tuser carries the first-character and
// empty-name flags, and tdata carries the character and the starting packet
// offset (read only with the first character). The master stream gives packet
// writes: tdata holds the byte and its position, tuser the write-valid flag and
// status, and tlast marks the final write of a name (terminator or error).
// A character is held in the input register and its writes are then loaded into
// the result buffer, from which the first of them is offered on the master stream.
// Throughput: one character per cycle while each gives at most one write and the
// receiver takes every write; a closing character gives up to three writes and then
// holds the input until the extra writes have left through the single output port
// of the result buffer.
// Reset clears the input register, the result buffer and the encoding state
// (positions and label length to zero, no name ended), so characters before
// any first character are placed from position zero.
// When the receiver stalls, buffered writes hold steady and the input stays
// open until its register is full; then s_axis_tready falls.
`default_nettype none
`include "dns_name_label_encoder_macros.svh"

module dns_name_label_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // name_char[7:0], start_offset[21:8], zero pad
	input  wire logic [1:0]  s_axis_tuser,  // first_char[0], empty_name[1]
	input  wire logic        s_axis_tlast,  // last_char
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // out_byte[7:0], out_pos[21:8], zero pad
	output logic [2:0]       m_axis_tuser,  // write_valid[0], status[2:1]
	output logic             m_axis_tlast   // name_done
);
	import dnle_pkg::*;

	// Input register stage.
	logic              valid_s1;
	logic [CHAR_W-1:0] name_char_s1;
	logic [POS_W-1:0]  start_offset_s1;
	logic              first_char_s1, last_char_s1, empty_name_s1;

	logic      room, proc, in_xfer;
	rbuf_ctl_t ctl;
	result_t   res [MAX_RESULTS];
	result_t   out_res;

	// A held character is processed once the result buffer can take all its writes.
	assign proc          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || proc;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			name_char_s1    <= s_axis_tdata[7:0];
			start_offset_s1 <= s_axis_tdata[21:8];
			first_char_s1   <= s_axis_tuser[0];
			empty_name_s1   <= s_axis_tuser[1];
			last_char_s1    <= s_axis_tlast;
		end
	end

	dnle_encode u_encode (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (proc),
		.name_char    (name_char_s1),
		.first_char   (first_char_s1),
		.last_char    (last_char_s1),
		.empty_name   (empty_name_s1),
		.start_offset (start_offset_s1),
		.ctl          (ctl),
		.res          (res)
	);

	dnle_rbuf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.res       (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.room      (room)
	);

	assign m_axis_tdata = {2'b00, out_res.out_pos, out_res.out_byte};
	assign m_axis_tuser = {out_res.status, out_res.write_valid};
	assign m_axis_tlast = out_res.name_done;

	// A write that is not made is always an error and always ends the name.
	`DNLE_ASSERT_NOW(a_err_ends_name, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tlast && (m_axis_tuser[2:1] == ST_LONG || m_axis_tuser[2:1] == ST_FULL),
		"dnle: dropped write without error end")
	// Every real write lands below the packet limit.
	`DNLE_ASSERT_NOW(a_pos_in_packet, m_axis_tvalid && m_axis_tuser[0],
		m_axis_tdata[21:8] < PACKET_LIMIT, "dnle: write at or beyond packet limit")
	// A successful finish is the terminator: a real zero write that ends the name.
	`DNLE_ASSERT_NOW(a_ok_is_term, m_axis_tvalid && m_axis_tuser[2:1] == ST_OK,
		m_axis_tlast && m_axis_tuser[0] && m_axis_tdata[7:0] == 8'h00,
		"dnle: bad terminator")
	// A character left waiting for buffer room is still held on the next cycle.
	`DNLE_ASSERT_NEXT(a_s1_holds, valid_s1 && !room, valid_s1,
		"dnle: waiting character lost")

endmodule

`default_nettype wire

>>> dv/dns_name_label_encoder_tb.sv
// Self-checking testbench for the DNS name label encoder, with predictor and write checker.
`timescale 1ns / 1ps

module dns_name_label_encoder_tb;
	import dnle_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned TAIL_CYCLES    = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // name_char[7:0], start_offset[21:8], zero pad
	logic [1:0]  s_axis_tuser = '0;  // first_char[0], empty_name[1]
	logic        s_axis_tlast = 1'b0;  // last_char
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // out_byte[7:0], out_pos[21:8], zero pad
	logic [2:0]  m_axis_tuser;  // write_valid[0], status[2:1]
	logic        m_axis_tlast;  // name_done

	dns_name_label_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Encoder state as the predictor sees it.
	logic [POS_W-1:0] wr_pos = '0;
	logic [POS_W-1:0] slot_pos = '0;
	logic [LEN_W-1:0] label_count = '0;
	bit               name_closed = 1'b0;

	result_t     pending_writes[$];
	int unsigned error_count = 0;
	int unsigned chars_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_req = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [POS_W-1:0] sat_next(input logic [POS_W-1:0] p);
		return p + POS_W'(p != POS_MAX);
	endfunction

	function automatic void queue_write(input logic [CHAR_W-1:0] b, input logic [POS_W-1:0] p,
			input logic v, input status_t s, input logic d);
		result_t w;
		w.out_byte    = b;
		w.out_pos     = p;
		w.write_valid = v;
		w.status      = s;
		w.name_done   = d;
		pending_writes = {pending_writes, w};
	endfunction

	// Works out the packet writes caused by one accepted character and updates the state.
	function automatic void predict_writes(input logic [CHAR_W-1:0] ch, input bit is_first,
			input bit is_last, input bit is_empty, input logic [POS_W-1:0] off);
		bit      failed;
		status_t fail_st;
		failed  = 1'b0;
		fail_st = ST_BUSY;
		if (is_empty) begin
			// An empty name only writes its terminator (or a full error), and only when it opens a name.
			if (!is_first)
				return;
			slot_pos    = off;
			wr_pos      = off;
			label_count = '0;
			name_closed = 1'b1;
			if (off >= PACKET_LIMIT) begin
				queue_write('0, '0, 1'b0, ST_FULL, 1'b1);
			end else begin
				queue_write('0, off, 1'b1, ST_OK, 1'b1);
				wr_pos = sat_next(off);
			end
			return;
		end
		if (is_first) begin
			// The first byte at the offset is reserved for the first label's length.
			name_closed = 1'b0;
			label_count = '0;
			slot_pos    = off;
			wr_pos      = sat_next(off);
		end
		if (name_closed)
			return;

		if (ch != DOT_CHAR) begin
			if (label_count >= MAX_LABEL) begin
				failed  = 1'b1;
				fail_st = ST_LONG;
			end else if (wr_pos >= PACKET_LIMIT) begin
				failed  = 1'b1;
				fail_st = ST_FULL;
			end else begin
				queue_write(ch, wr_pos, 1'b1, ST_BUSY, 1'b0);
				wr_pos      = sat_next(wr_pos);
				label_count = label_count + LEN_W'(1);
			end
		end else begin
			if (slot_pos >= PACKET_LIMIT) begin
				failed  = 1'b1;
				fail_st = ST_FULL;
			end else begin
				queue_write({1'b0, label_count}, slot_pos, 1'b1, ST_BUSY, 1'b0);
				// A dot on the last character is a trailing dot and opens no label.
				if (!is_last) begin
					slot_pos    = wr_pos;
					wr_pos      = sat_next(wr_pos);
					label_count = '0;
				end
			end
		end

		if (!failed && is_last) begin
			if (ch != DOT_CHAR) begin
				if (slot_pos >= PACKET_LIMIT) begin
					failed  = 1'b1;
					fail_st = ST_FULL;
				end else begin
					queue_write({1'b0, label_count}, slot_pos, 1'b1, ST_BUSY, 1'b0);
				end
			end
			if (!failed) begin
				if (wr_pos >= PACKET_LIMIT) begin
					failed  = 1'b1;
					fail_st = ST_FULL;
				end else begin
					queue_write('0, wr_pos, 1'b1, ST_OK, 1'b1);
					wr_pos      = sat_next(wr_pos);
					name_closed = 1'b1;
				end
			end
		end

		if (failed) begin
			queue_write('0, '0, 1'b0, fail_st, 1'b1);
			name_closed = 1'b1;
		end
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		error_count++;
	endtask

	// Offers one character, waits for its transfer and records the writes it should cause.
	task automatic send_char(input logic [CHAR_W-1:0] ch, input bit is_first, input bit is_last,
			input bit is_empty, input logic [POS_W-1:0] off);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, off, ch};
		s_axis_tuser  <= {is_empty, is_first};
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		predict_writes(ch, is_first, is_last, is_empty, off);
		chars_sent++;
	endtask

	task automatic send_name(input logic [CHAR_W-1:0] chars[$], input logic [POS_W-1:0] off,
			input bit with_first, input bit with_last);
		foreach (chars[i])
			send_char(chars[i], with_first && i == 0, with_last && i == chars.size() - 1,
				1'b0, off);
	endtask

	task automatic send_text(input string text, input logic [POS_W-1:0] off,
			input bit with_first, input bit with_last);
		logic [CHAR_W-1:0] chars[$];
		for (int i = 0; i < text.len(); i++)
			chars = {chars, CHAR_W'(text[i])};
		send_name(chars, off, with_first, with_last);
	endtask

	// The sender stops offering and waits until every predicted write has been seen.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_writes.size() != 0);
	endtask

	function automatic logic [CHAR_W-1:0] pick_label_char();
		logic [CHAR_W-1:0] c;
		do c = CHAR_W'($urandom); while (c == DOT_CHAR);
		return c;
	endfunction

	// Mostly low offsets, with some close to the packet limit so that names run out of room.
	function automatic logic [POS_W-1:0] pick_offset();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75)
			return POS_W'($urandom_range(0, 200));
		else if (r < 88)
			return POS_W'($urandom_range(8800, 9000));
		return POS_W'($urandom_range(0, 9000));
	endfunction

	// Characters before any first character are placed from the reset state.
	task automatic test_reset_state();
		send_text("ab.c", '0, 1'b0, 1'b1);
	endtask

	task automatic test_directed_names();
		send_text("a.bc", 14'd0, 1'b1, 1'b1);
		send_text("x.", 14'd20, 1'b1, 1'b1);     // trailing dot
		send_text(".y", 14'd40, 1'b1, 1'b1);     // leading empty label
		send_text("p..q", 14'd60, 1'b1, 1'b1);   // empty label in the middle
		send_text("z", 14'd80, 1'b1, 1'b1);      // one character gives all three writes
		send_text(".", 14'd90, 1'b1, 1'b1);      // lone dot
		send_char(8'hFF, 1'b1, 1'b0, 1'b0, 14'd100);
		send_char(8'h00, 1'b0, 1'b1, 1'b0, 14'h3FFF);
		send_char("q", 1'b0, 1'b1, 1'b0, 14'd0);  // name already ended, ignored
		send_char(8'hA5, 1'b1, 1'b0, 1'b1, 14'd200);
		send_char(8'h00, 1'b0, 1'b1, 1'b1, 14'd0);  // empty name without first, ignored
		send_char(8'h5A, 1'b1, 1'b1, 1'b1, PACKET_LIMIT);
		send_text("ab", 14'd8998, 1'b1, 1'b1);   // second character runs past the limit
		send_text("a", 14'd8998, 1'b1, 1'b1);    // terminator runs past the limit
		send_text("a", 14'd8997, 1'b1, 1'b1);    // terminator lands on the last position
		send_text(".", PACKET_LIMIT, 1'b1, 1'b1);
		send_text("k", 14'd9000, 1'b1, 1'b1);
	endtask

	task automatic test_long_label();
		logic [CHAR_W-1:0] chars[$];
		// A label of exactly the maximum length, then one more label.
		repeat (MAX_LABEL) chars = {chars, pick_label_char()};
		chars = {chars, DOT_CHAR};
		chars = {chars, CHAR_W'("b")};
		send_name(chars, 14'd300, 1'b1, 1'b1);
		// More characters than the maximum: the first extra one ends the name and the rest is ignored.
		chars.delete();
		repeat (MAX_LABEL + 3) chars = {chars, pick_label_char()};
		send_name(chars, 14'd500, 1'b1, 1'b1);
		wait_drained();
	endtask

	// The receiver holds off while names keep coming, so the block fills and stalls its input.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = HOLD_CYCLES;
		send_text("mail.example.org", 14'd12, 1'b1, 1'b1);
		send_text("a.b.c.d", 14'd40, 1'b1, 1'b1);
		send_text("xy.", 14'd60, 1'b1, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned n_items);
		logic [CHAR_W-1:0] chars[$];
		int unsigned       target;
		int unsigned       kind;
		int unsigned       n_labels;
		int unsigned       len;
		int unsigned       r;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		target         = chars_sent + n_items;
		while (chars_sent < target) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				// Noise: arbitrary flags and offsets.
				repeat ($urandom_range(1, 4))
					send_char(CHAR_W'($urandom), $urandom_range(3) == 0,
						$urandom_range(3) == 0, $urandom_range(7) == 0,
						POS_W'($urandom_range(0, 9000)));
			end else if (kind < 13) begin
				send_char(CHAR_W'($urandom), 1'b1, 1'($urandom_range(1)), 1'b1,
					pick_offset());
			end else begin
				chars.delete();
				n_labels = $urandom_range(1, 4);
				for (int l = 0; l < n_labels; l++) begin
					if (l != 0)
						chars = {chars, DOT_CHAR};
					r = $urandom_range(99);
					if (r < 3)
						len = $urandom_range(MAX_LABEL - 1, MAX_LABEL + 1);
					else if (r < 12)
						len = $urandom_range(9, 20);
					else
						len = $urandom_range(0, 8);
					repeat (len) chars = {chars, pick_label_char()};
				end
				if ($urandom_range(4) == 0)
					chars = {chars, DOT_CHAR};
				if (chars.size() == 0)
					chars = {chars, pick_label_char()};
				// Some names are cut short and never see their last character.
				send_name(chars, pick_offset(), 1'b1, $urandom_range(99) >= 15);
			end
		end
		wait_drained();
	endtask

	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compares every write transfer with the oldest predicted write.
	initial begin : write_checker
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (pending_writes.size() == 0) begin
					report_mismatch("write with none pending, position",
						32'(m_axis_tdata[21:8]), 0);
				end else begin
					want = pending_writes.pop_front();
					if (m_axis_tdata[7:0] != want.out_byte)
						report_mismatch("out_byte", 32'(m_axis_tdata[7:0]),
							32'(want.out_byte));
					if (m_axis_tdata[21:8] != want.out_pos)
						report_mismatch("out_pos", 32'(m_axis_tdata[21:8]),
							32'(want.out_pos));
					if (m_axis_tuser[0] != want.write_valid)
						report_mismatch("write_valid", 32'(m_axis_tuser[0]),
							32'(want.write_valid));
					if (m_axis_tuser[2:1] != want.status)
						report_mismatch("status", 32'(m_axis_tuser[2:1]),
							32'(want.status));
					if (m_axis_tlast != want.name_done)
						report_mismatch("name_done", 32'(m_axis_tlast),
							32'(want.name_done));
				end
			end
		end
	end

	// Ends the run when no transfer has happened on either side for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : main
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_directed_names();
		test_long_label();
		test_backpressure();
		test_random_traffic(0, 0, 65);
		test_random_traffic(76, 0, 65);
		test_random_traffic(0, 76, 65);
		test_random_traffic(26, 26, 65);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
